// ===== rtl/core/bft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_pkg
// Shared constants and types for the bidirectional flow table.
// ----------------------------------------------------------------------------
package bft_pkg;

    localparam int TABLE_ENTRIES_DEF     = 64;
    localparam int BYTE_COUNT_BITS_DEF   = 48;
    localparam int PACKET_COUNT_BITS_DEF = 32;

    // Key word: src_hi, src_lo, dst_hi, dst_lo, ports, proto
    localparam int KEY_BITS  = 64 * 4 + 32 + 8;
    localparam int IN_BITS   = KEY_BITS + 16;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_KEY_BITS = KEY_BITS;
    localparam int OUT_BITS  = OUT_KEY_BITS + 48 * 2 + 32 * 2;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    typedef logic [KEY_BITS-1:0] key_t;

endpackage

// ===== rtl/core/bft_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/bidirectional_flow_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidirectional_flow_table
// Five-tuple flow table with tx/rx counters and a sorted drain.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word: req_type in tuser, the key and packet
//   length in tdata. m_axis carries one flow word per emitted flow during a
//   drain, last_flow on tlast. sort_mode is written through cfg_we/cfg_data.
//   Packet update: the table is scanned slot by slot through the key RAM,
//   one slot a cycle, comparing forward and swapped keys together; then the
//   hit decision and a counter read-modify-write. A miss inserts the key in
//   the lowest free slot; with the table full it is dropped and counted.
//   Drain: each emitted flow takes one full scan of the counter RAMs to find
//   the largest total, then a key and counter read. Ties go to the lower
//   slot. Valid bits clear after the last flow word is loaded for output.
//   Reset clears valid bits, the drop counter and sort_mode; no clearing
//   pass is needed. When m_axis_tready is low the block holds the word and
//   waits; s_axis_tready stays low until the current request is finished.
// ----------------------------------------------------------------------------
module bidirectional_flow_table #(
    parameter int TABLE_ENTRIES     = bft_pkg::TABLE_ENTRIES_DEF,
    parameter int BYTE_COUNT_BITS   = bft_pkg::BYTE_COUNT_BITS_DEF,
    parameter int PACKET_COUNT_BITS = bft_pkg::PACKET_COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, src_port,
    // dst_port, protocol, packet_length
    input  logic [bft_pkg::IN_BYTES*8-1:0] s_axis_tdata,
    // req_type
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // flow_src_hi, flow_src_lo, flow_dst_hi, flow_dst_lo, flow_src_port,
    // flow_dst_port, flow_protocol, tx_bytes, rx_bytes, tx_packets, rx_packets
    output logic [bft_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
    // last_flow
    output logic m_axis_tlast
);
    import bft_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;
    localparam int BW = BYTE_COUNT_BITS;
    localparam int PW = PACKET_COUNT_BITS;
    localparam int TW = (BW > PW ? BW : PW) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_END, S_CNT_RD, S_CNT_WAIT, S_CNT_WR0, S_CNT_WR1,
        S_INS, S_DR_SCAN, S_DR_KEY, S_DR_KEY_WAIT, S_DR_OUT
    } state_t;

    state_t state_reg;
    logic sort_mode_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg, done_reg;
    logic [31:0] dropped_reg;
    key_t fwd_reg, rev_reg;
    logic [15:0] len_reg;
    logic [CW-1:0] idx_reg;        // issue index
    logic [IW-1:0] chk_reg;        // slot whose data is on the RAM output
    logic chk_vld_reg;
    logic fhit_reg, rhit_reg;
    logic [IW-1:0] fslot_reg, rslot_reg, hit_slot_reg;
    logic dir_reg;
    logic [CW:0] cidx_reg;         // counter RAM issue index
    logic [CW:0] cchk_reg;
    logic cchk_vld_reg;
    logic [BW-1:0] half_b_reg;
    logic [PW-1:0] half_p_reg;
    logic best_vld_reg;
    logic [TW-1:0] best_tot_reg;
    logic [IW-1:0] best_reg;
    logic [CW-1:0] remain_reg;
    logic [BW-1:0] txb_reg;
    logic [PW-1:0] txp_reg;
    logic [OUT_BYTES*8-1:0] odata_reg;
    logic ovalid_reg, olast_reg;

    // key RAM
    logic key_we;
    logic [IW-1:0] key_waddr, key_raddr;
    key_t key_rdata;
    // counter RAMs, address {slot, dir}
    logic cnt_we;
    logic [IW:0] cnt_waddr, cnt_raddr;
    logic [BW-1:0] b_wdata, b_rdata;
    logic [PW-1:0] p_wdata, p_rdata;

    bft_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(fwd_reg),
        .raddr(key_raddr), .rdata(key_rdata)
    );
    bft_ram #(.WIDTH(BW), .DEPTH(2 * TABLE_ENTRIES)) u_byte_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(b_wdata),
        .raddr(cnt_raddr), .rdata(b_rdata)
    );
    bft_ram #(.WIDTH(PW), .DEPTH(2 * TABLE_ENTRIES)) u_pkt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(p_wdata),
        .raddr(cnt_raddr), .rdata(p_rdata)
    );

    // lowest free slot
    logic free_any;
    logic [IW-1:0] free_slot;
    always_comb
    begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any  = 1'b1;
                free_slot = IW'(i);
            end
        end
    end

    // saturating counter update on the counter read data
    logic [BW:0] b_sum;
    logic [PW:0] p_sum;
    logic [BW-1:0] b_new;
    logic [PW-1:0] p_new;
    always_comb
    begin
        b_sum = {1'b0, b_rdata} + (BW + 1)'(len_reg);
        p_sum = {1'b0, p_rdata} + (PW + 1)'(1);
        b_new = b_sum[BW] ? {BW{1'b1}} : b_sum[BW-1:0];
        p_new = p_sum[PW] ? {PW{1'b1}} : p_sum[PW-1:0];
    end

    // total of the tx half and the rx half now on the RAM output
    logic [TW-1:0] tot;
    always_comb
    begin
        if (sort_mode_reg)
        begin
            tot = TW'(half_p_reg) + TW'(p_rdata);
        end
        else
        begin
            tot = TW'(half_b_reg) + TW'(b_rdata);
        end
    end

    logic [IW-1:0] cslot;
    assign cslot = cchk_reg[IW:1];

    // RAM control
    always_comb
    begin
        key_we    = (state_reg == S_INS);
        key_waddr = free_slot;
        key_raddr = (state_reg == S_DR_KEY || state_reg == S_DR_KEY_WAIT ||
                     state_reg == S_DR_OUT) ? best_reg : idx_reg[IW-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = {hit_slot_reg, dir_reg};
        b_wdata   = b_new;
        p_wdata   = p_new;
        cnt_raddr = (state_reg == S_DR_KEY) ? {best_reg, 1'b0} : cidx_reg[IW:0];
        case (state_reg)
            S_CNT_WAIT: cnt_raddr = {hit_slot_reg, dir_reg};
            S_CNT_WR0:  cnt_we = 1'b1;
            S_INS:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = {free_slot, 1'b0};
                b_wdata   = BW'(len_reg);
                p_wdata   = PW'(1);
            end
            S_CNT_WR1:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = {free_slot, 1'b1};
                b_wdata   = '0;
                p_wdata   = '0;
            end
            S_DR_KEY_WAIT, S_DR_OUT: cnt_raddr = {best_reg, 1'b1};
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    key_t in_key;
    assign in_key = s_axis_tdata[KEY_BITS-1:0];

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sort_mode_reg <= 1'b0;
            valid_reg     <= '0;
            done_reg      <= '0;
            dropped_reg   <= '0;
            ovalid_reg    <= 1'b0;
            olast_reg     <= 1'b0;
            chk_vld_reg   <= 1'b0;
            cchk_vld_reg  <= 1'b0;
            best_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sort_mode_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        // forward key, and the swapped key for the rx direction
                        fwd_reg <= in_key;
                        rev_reg <= {in_key[295:288], in_key[271:256], in_key[287:272],
                                    in_key[127:64], in_key[63:0], in_key[255:192],
                                    in_key[191:128]};
                        len_reg <= s_axis_tdata[KEY_BITS+15:KEY_BITS];
                        idx_reg <= '0;
                        cidx_reg <= '0;
                        chk_vld_reg <= 1'b0;
                        cchk_vld_reg <= 1'b0;
                        fhit_reg <= 1'b0;
                        rhit_reg <= 1'b0;
                        done_reg <= '0;
                        best_vld_reg <= 1'b0;
                        remain_reg <= CW'($countones(valid_reg));
                        state_reg <= (s_axis_tuser == REQ_DRAIN) ? S_DR_SCAN : S_SCAN;
                    end
                end
                S_SCAN, S_SCAN_END:
                begin
                    // compare the slot read last cycle; lowest hit wins
                    if (chk_vld_reg && valid_reg[chk_reg])
                    begin
                        if (!fhit_reg && key_rdata == fwd_reg)
                        begin
                            fhit_reg  <= 1'b1;
                            fslot_reg <= chk_reg;
                        end
                        if (!rhit_reg && key_rdata == rev_reg)
                        begin
                            rhit_reg  <= 1'b1;
                            rslot_reg <= chk_reg;
                        end
                    end
                    chk_reg     <= idx_reg[IW-1:0];
                    chk_vld_reg <= (state_reg == S_SCAN);
                    idx_reg     <= idx_reg + CW'(1);
                    if (state_reg == S_SCAN_END)
                    begin
                        state_reg <= S_CNT_RD;
                    end
                    else if (idx_reg == CW'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= S_SCAN_END;
                    end
                end
                S_CNT_RD:
                begin
                    // decided after the scan, once the final compare in S_SCAN_END is done
                    if (fhit_reg)
                    begin
                        hit_slot_reg <= fslot_reg;
                        dir_reg      <= 1'b0;
                        state_reg    <= S_CNT_WAIT;
                    end
                    else if (rhit_reg)
                    begin
                        hit_slot_reg <= rslot_reg;
                        dir_reg      <= 1'b1;
                        state_reg    <= S_CNT_WAIT;
                    end
                    else if (free_any)
                    begin
                        state_reg <= S_INS;
                    end
                    else
                    begin
                        if (dropped_reg != 32'hFFFF_FFFF)
                        begin
                            dropped_reg <= dropped_reg + 32'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_CNT_WAIT:
                begin
                    // address was set from hit_slot_reg in this cycle
                    state_reg <= S_CNT_WR0;
                end
                S_CNT_WR0:
                begin
                    state_reg <= S_IDLE;
                end
                S_INS:
                begin
                    state_reg <= S_CNT_WR1;
                end
                S_CNT_WR1:
                begin
                    valid_reg[free_slot] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DR_SCAN:
                begin
                    // even address: hold tx half, odd address: form total
                    if (cchk_vld_reg)
                    begin
                        if (!cchk_reg[0])
                        begin
                            half_b_reg <= b_rdata;
                            half_p_reg <= p_rdata;
                        end
                        else if (valid_reg[cslot] && !done_reg[cslot] &&
                                 (!best_vld_reg || tot > best_tot_reg))
                        begin
                            best_vld_reg <= 1'b1;
                            best_tot_reg <= tot;
                            best_reg     <= cslot;
                        end
                    end
                    cchk_reg     <= cidx_reg;
                    cchk_vld_reg <= (cidx_reg != (CW + 1)'(2 * TABLE_ENTRIES));
                    if (remain_reg == '0)
                    begin
                        valid_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (cidx_reg == (CW + 1)'(2 * TABLE_ENTRIES) && !cchk_vld_reg)
                    begin
                        state_reg <= S_DR_KEY;
                    end
                    else if (cidx_reg != (CW + 1)'(2 * TABLE_ENTRIES))
                    begin
                        cidx_reg <= cidx_reg + (CW + 1)'(1);
                    end
                end
                S_DR_KEY:
                begin
                    state_reg <= S_DR_KEY_WAIT;
                end
                S_DR_KEY_WAIT:
                begin
                    txb_reg <= b_rdata;
                    txp_reg <= p_rdata;
                    state_reg <= S_DR_OUT;
                end
                S_DR_OUT:
                begin
                    // key and rx half stay on the RAM outputs while waiting
                    if (!ovalid_reg)
                    begin
                        odata_reg <= {32'(p_rdata), 32'(txp_reg), 48'(b_rdata),
                                      48'(txb_reg), key_rdata};
                        ovalid_reg <= 1'b1;
                        olast_reg  <= (remain_reg == CW'(1));
                        done_reg[best_reg] <= 1'b1;
                        remain_reg <= remain_reg - CW'(1);
                        best_vld_reg <= 1'b0;
                        cidx_reg <= '0;
                        cchk_vld_reg <= 1'b0;
                        state_reg <= S_DR_SCAN;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    logic unused_drop;
    assign unused_drop = ^dropped_reg;

endmodule
